// ===== sv/ctcgd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctcgd_pkg
// Shared types and constants of the greedy ctc text decoder: class index
// width, alphabet limits, ascii mapping and the row result record.
// ----------------------------------------------------------------------------
package ctcgd_pkg;

  // class index width and saturation value of the class counter
  localparam int unsigned ClassBits = 6;
  localparam logic [ClassBits-1:0] CounterMax = 6'd63;

  // alphabet: classes 1..10 are digits, 11..36 lower-case letters
  localparam logic [ClassBits-1:0] AlphabetSize   = 6'd36;
  localparam logic [ClassBits-1:0] LastDigitClass = 6'd10;
  localparam logic [ClassBits-1:0] BlankClass     = 6'd0;

  // ascii offsets: '0' - 1 and 'a' - 11, and the code shown for no symbol
  localparam logic [7:0] DigitBase  = 8'h2F;
  localparam logic [7:0] LetterBase = 8'h56;
  localparam logic [7:0] BlankCode  = 8'h2D;

  // one finished time step, passed from front to back
  typedef struct packed {
    logic [ClassBits-1:0] best_class;
    logic                 word_end;
  } row_result_t;

  // ascii of a symbol class, valid for classes 1..36
  function automatic logic [7:0] symbol_ascii(input logic [ClassBits-1:0] cls);
    logic [7:0] wide_cls;
    wide_cls = {2'b00, cls};
    if (cls <= LastDigitClass) begin
      return DigitBase + wide_cls;
    end else begin
      return LetterBase + wide_cls;
    end
  endfunction

endpackage : ctcgd_pkg
`default_nettype wire

// ===== sv/ctcgd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctcgd_front
// Input side: tracks the running maximum of each row, the class of that
// maximum and the class counter, and hands the row winner to the queue on
// the row's last score.
// ----------------------------------------------------------------------------
module ctcgd_front
  import ctcgd_pkg::*;
#(
  parameter int unsigned SCORE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [SCORE_BITS-1:0] score_i,
  input  logic                         row_end_i,
  input  logic                         word_end_i,
  output logic                         push_o,
  output row_result_t                  push_data_o,
  input  logic                         queue_ready_i
);

  logic signed [SCORE_BITS-1:0] running_max_q, running_max_d;
  logic [ClassBits-1:0]         running_best_q, running_best_d;
  logic [ClassBits-1:0]         class_counter_q, class_counter_d;
  logic                         accept;
  logic                         take;
  logic [ClassBits-1:0]         step_best;

  assign in_ready_o = queue_ready_i;
  assign accept     = in_valid_i & queue_ready_i;

  // compare against the running maximum; the first class of a row is always taken, a tie keeps the earlier class
  assign take      = (class_counter_q == BlankClass) || (score_i > running_max_q);
  assign step_best = take ? class_counter_q : running_best_q;

  // row winner goes to the queue on the row's last score
  assign push_o                  = accept & row_end_i;
  assign push_data_o.best_class  = step_best;
  assign push_data_o.word_end    = word_end_i;

  // next row state
  always_comb begin
    running_max_d   = running_max_q;
    running_best_d  = running_best_q;
    class_counter_d = class_counter_q;
    if (accept) begin
      if (row_end_i) begin
        running_max_d   = {1'b1, {(SCORE_BITS-1){1'b0}}};
        running_best_d  = BlankClass;
        class_counter_d = BlankClass;
      end else begin
        if (take) begin
          running_max_d  = score_i;
          running_best_d = class_counter_q;
        end
        if (class_counter_q < CounterMax) begin
          class_counter_d = class_counter_q + 1'b1;
        end
      end
    end
  end

  // row state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_max_q   <= {1'b1, {(SCORE_BITS-1){1'b0}}};
      running_best_q  <= BlankClass;
      class_counter_q <= BlankClass;
    end else begin
      running_max_q   <= running_max_d;
      running_best_q  <= running_best_d;
      class_counter_q <= class_counter_d;
    end
  end

endmodule : ctcgd_front
`default_nettype wire

// ===== sv/ctcgd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctcgd_queue
// Two-entry queue of row results between the front and the back, so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module ctcgd_queue
  import ctcgd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  row_result_t push_data_i,
  output logic        ready_o,
  input  logic        pop_i,
  output row_result_t pop_data_o,
  output logic        not_empty_o
);

  localparam int unsigned Depth     = 2;
  localparam int unsigned PtrBits   = $clog2(Depth);
  localparam int unsigned CountBits = $clog2(Depth + 1);

  row_result_t          mem_q [Depth];
  logic [PtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CountBits-1:0] count_q, count_d;
  logic                 do_push;
  logic                 do_pop;

  assign ready_o     = (count_q != CountBits'(Depth));
  assign not_empty_o = (count_q != '0);
  assign do_push     = push_i & ready_o;
  assign do_pop      = pop_i & not_empty_o;
  assign pop_data_o  = mem_q[rd_ptr_q];

  // pointer and fill level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    priority if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // fill level never passes the depth
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountBits'(Depth))
    else $error("queue fill level beyond depth");

  // a lone push raises the fill level by one
  a_push_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue push lost");

  // pointers are equal whenever the queue is empty or full
  a_ptr_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((count_q == '0) || (count_q == CountBits'(Depth))) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers out of step with fill level");

endmodule : ctcgd_queue
`default_nettype wire

// ===== sv/ctcgd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctcgd_back
// Output side: maps the row winner to a symbol, suppresses blanks and
// repeats of the previous step's symbol, and holds the result in an output
// register until the receiver takes it.
// ----------------------------------------------------------------------------
module ctcgd_back
  import ctcgd_pkg::*;
#(
  parameter int unsigned CLASS_COUNT = 37
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  row_result_t          head_i,
  input  logic                 head_valid_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 symbol_valid_o,
  output logic [7:0]           symbol_code_o,
  output logic [ClassBits-1:0] best_class_o,
  output logic                 sequence_done_o
);

  logic                 out_valid_q;
  logic                 symbol_valid_q;
  logic [7:0]           symbol_code_q;
  logic [ClassBits-1:0] best_class_q;
  logic                 sequence_done_q;
  logic [ClassBits-1:0] prev_symbol_q, prev_symbol_d;
  logic                 is_symbol;
  logic [ClassBits-1:0] sym;
  logic                 emit;
  logic                 load;

  // output register free or emptied this cycle
  assign load  = head_valid_i & (~out_valid_q | out_ready_i);
  assign pop_o = load;

  // blank test and repeat suppression
  assign is_symbol = (head_i.best_class != BlankClass) &&
                     (head_i.best_class <= AlphabetSize) &&
                     ({1'b0, head_i.best_class} < (ClassBits + 1)'(CLASS_COUNT));
  assign sym  = is_symbol ? head_i.best_class : BlankClass;
  assign emit = is_symbol && (sym != prev_symbol_q);

  assign prev_symbol_d = head_i.word_end ? BlankClass : sym;

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      symbol_valid_q  <= emit;
      symbol_code_q   <= emit ? symbol_ascii(sym) : BlankCode;
      best_class_q    <= head_i.best_class;
      sequence_done_q <= head_i.word_end;
    end
  end

  // output valid and previous symbol
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      prev_symbol_q <= BlankClass;
    end else begin
      if (load) begin
        out_valid_q   <= 1'b1;
        prev_symbol_q <= prev_symbol_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign symbol_valid_o  = symbol_valid_q;
  assign symbol_code_o   = symbol_code_q;
  assign best_class_o    = best_class_q;
  assign sequence_done_o = sequence_done_q;

endmodule : ctcgd_back
`default_nettype wire

// ===== sv/ctc_greedy_text_decode_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctc_greedy_text_decode_top
// Greedy ctc decoder for a stream of recognizer class scores.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one class score per transaction, class 0 first;
//   tlast marks the last score of a time step and tuser the last step of a
//   word (read only together with tlast). Every transaction with tlast set
//   produces exactly one master transaction: the winning class, its ascii
//   symbol when the step appends one, and tlast on the word's last step.
//   Throughput is one score per cycle while the queue has room, including
//   rows of a single score; the compare-and-update in the front unit is the
//   only per-score work. The row result is written into the queue and then
//   loaded into the output register, from which it is valid on the master
//   side.
//   Reset clears the row state, the previous symbol and the queue; the
//   master side comes out of reset idle.
//   When the receiver stalls, the output register and a two-entry queue of
//   row results fill up, and then s_tready_o falls for every score, inside
//   a row or at its end, until the queue has room again.
// ----------------------------------------------------------------------------
module ctc_greedy_text_decode_top
  import ctcgd_pkg::*;
#(
  parameter int unsigned CLASS_COUNT = 37,
  parameter int unsigned SCORE_BITS  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // slave stream
  input  logic                                 s_tvalid_i,
  output logic                                 s_tready_o,
  input  logic [((SCORE_BITS + 7) / 8) * 8-1:0] s_tdata_i, // score, zero padding
  input  logic                                 s_tlast_i, // row_end
  input  logic                                 s_tuser_i, // word_end
  // master stream
  output logic                                 m_tvalid_o,
  input  logic                                 m_tready_i,
  output logic [15:0]                          m_tdata_o, // symbol_code, best_class, zero
  output logic                                 m_tlast_o, // sequence_done
  output logic                                 m_tuser_o  // symbol_valid
);

  logic                         push;
  row_result_t                  push_data;
  logic                         queue_ready;
  logic                         pop;
  row_result_t                  head;
  logic                         head_valid;
  logic [7:0]                   symbol_code;
  logic [ClassBits-1:0]         best_class;
  logic signed [SCORE_BITS-1:0] score;

  assign score = signed'(s_tdata_i[SCORE_BITS-1:0]);

  // row maximum tracking
  ctcgd_front #(
    .SCORE_BITS (SCORE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_tvalid_i),
    .in_ready_o    (s_tready_o),
    .score_i       (score),
    .row_end_i     (s_tlast_i),
    .word_end_i    (s_tuser_i),
    .push_o        (push),
    .push_data_o   (push_data),
    .queue_ready_i (queue_ready)
  );

  // row results between front and back
  ctcgd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .ready_o     (queue_ready),
    .pop_i       (pop),
    .pop_data_o  (head),
    .not_empty_o (head_valid)
  );

  // symbol mapping and output register
  ctcgd_back #(
    .CLASS_COUNT (CLASS_COUNT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .head_valid_i    (head_valid),
    .pop_o           (pop),
    .out_valid_o     (m_tvalid_o),
    .out_ready_i     (m_tready_i),
    .symbol_valid_o  (m_tuser_o),
    .symbol_code_o   (symbol_code),
    .best_class_o    (best_class),
    .sequence_done_o (m_tlast_o)
  );

  // pack the master data word
  assign m_tdata_o = {{(16 - 8 - ClassBits){1'b0}}, best_class, symbol_code};

endmodule : ctc_greedy_text_decode_top
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the greedy ctc text decoder. A queue of class
// scores, directed rows first and then random words, feeds a stream driver
// with random gaps. The driver updates a local model of the row maximum and
// the previous symbol for every accepted score. The monitor stalls at random
// and compares every row result with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_top;
  import ctcgd_pkg::*;

  localparam int CLASS_COUNT   = 37;
  localparam int SCORE_W       = 16;
  localparam int RANDOM_SCORES = 600;
  localparam int MIN_ROWS      = 60;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 8;
  localparam int QUIET_LIMIT   = 2000;

  // one class score as offered on the slave side, or a pause marker
  typedef struct {
    logic signed [SCORE_W-1:0] score;
    logic                      row_end;
    logic                      word_end;
    bit                        drain;
  } score_item_t;

  // one decoded time step as expected on the master side
  typedef struct {
    logic                 symbol_valid;
    logic [7:0]           symbol_code;
    logic [ClassBits-1:0] best_class;
    logic                 sequence_done;
  } step_result_t;

  logic                clk_i    = 1'b0;
  logic                rst_n    = 1'b0;
  logic                s_tvalid = 1'b0;
  logic [SCORE_W-1:0]  s_tdata  = '0;
  logic                s_tlast  = 1'b0;
  logic                s_tuser  = 1'b0;
  logic                m_tready = 1'b0;
  logic                s_tready_o;
  logic                m_tvalid_o;
  logic [15:0]         m_tdata_o;
  logic                m_tlast_o;
  logic                m_tuser_o;

  score_item_t  score_feed[$];
  step_result_t step_results[$];

  // decoder model state
  logic signed [SCORE_W-1:0] row_max     = -16'sd32768;
  logic [ClassBits-1:0]      row_best    = BlankClass;
  logic [ClassBits-1:0]      class_idx   = '0;
  logic [ClassBits-1:0]      prev_symbol = BlankClass;
  string                     alphabet    = "0123456789abcdefghijklmnopqrstuvwxyz";

  int errors       = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int scores_made  = 0;
  int rows_made    = 0;
  int last_win     = 0;

  // driver and monitor working state
  score_item_t  drv_item;
  step_result_t want;
  int  send_gap     = 0;
  int  drain_settle = 0;
  bit  send_burst   = 1'b0;
  int  recv_gap     = 0;
  int  hold_left    = 0;
  bit  recv_burst   = 1'b0;

  always #5 clk_i = ~clk_i;

  ctc_greedy_text_decode_top #(
    .CLASS_COUNT(CLASS_COUNT),
    .SCORE_BITS (SCORE_W)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_n),
    .s_tvalid_i(s_tvalid),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata),
    .s_tlast_i (s_tlast),
    .s_tuser_i (s_tuser),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready),
    .m_tdata_o (m_tdata_o),
    .m_tlast_o (m_tlast_o),
    .m_tuser_o (m_tuser_o)
  );

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // running maximum per row, symbol decision on the row's last score
  task automatic decode_score(input score_item_t it);
    logic [ClassBits-1:0] sym;
    step_result_t         r;
    if (class_idx == '0 || it.score > row_max) begin
      row_max  = it.score;
      row_best = class_idx;
    end
    if (class_idx != CounterMax) class_idx++;
    if (it.row_end) begin
      sym = (row_best != BlankClass && row_best <= AlphabetSize && row_best < CLASS_COUNT)
            ? row_best : BlankClass;
      r.symbol_valid  = (sym != BlankClass) && (sym != prev_symbol);
      r.symbol_code   = r.symbol_valid ? alphabet[sym - 1] : BlankCode;
      r.best_class    = row_best;
      r.sequence_done = it.word_end;
      step_results.insert(step_results.size(), r);
      prev_symbol = it.word_end ? BlankClass : sym;
      row_max     = -16'sd32768;
      row_best    = BlankClass;
      class_idx   = '0;
    end
  endtask

  task automatic push_score(input int score, input bit row_end, input bit word_end);
    score_item_t it;
    it.score    = score[SCORE_W-1:0];
    it.row_end  = row_end;
    it.word_end = word_end;
    it.drain    = 1'b0;
    score_feed.insert(score_feed.size(), it);
    scores_made++;
    if (row_end) rows_made++;
  endtask

  task automatic push_drain();
    score_item_t it;
    it.score    = '0;
    it.row_end  = 1'b0;
    it.word_end = 1'b0;
    it.drain    = 1'b1;
    score_feed.insert(score_feed.size(), it);
  endtask

  // random row: mostly a planted winner over nearby scores, some flat noise
  task automatic push_random_row();
    int len, win, pick, top, val, k;
    bit flat, wend;
    pick = $urandom_range(0, 9);
    if (pick < 6) len = $urandom_range(1, 12);
    else if (pick < 9) len = $urandom_range(13, 40);
    else len = $urandom_range(41, 72);
    win = $urandom_range(0, len - 1);
    // repeat the previous winner now and then to hit symbol collapsing
    if ($urandom_range(0, 3) == 0 && last_win < 40) begin
      win = last_win;
      if (len <= win) len = win + 1;
    end
    last_win = win;
    flat = ($urandom_range(0, 4) == 0);
    top  = ($urandom_range(0, 3) == 0) ? 32767 : int'($urandom_range(0, 65535)) - 32768;
    for (k = 0; k < len; k++) begin
      if (flat) val = int'($urandom_range(0, 65535)) - 32768;
      else if (k == win) val = top;
      else begin
        val = top - int'($urandom_range(0, 3000));
        if (val < -32768) val = -32768;
      end
      wend = (k == len - 1) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) == 0);
      push_score(val, k == len - 1, wend);
    end
  endtask

  // stimulus, reset and end of run
  initial begin
    // single score row: class 0, blank
    push_score(0, 1, 0);
    // extremes, class 1 wins, then the same symbol again collapses
    push_score(-32768, 0, 0);
    push_score(32767, 1, 0);
    push_score(-32768, 0, 0);
    push_score(32767, 1, 0);
    // tie across the row, first class wins
    push_score(5, 0, 0);
    push_score(5, 0, 0);
    push_score(5, 1, 0);
    // symbol after a blank step is emitted again, word ends
    push_score(-5, 0, 0);
    push_score(7, 1, 1);
    // word end without row end is ignored; tie on the maximum keeps class 1
    push_score(-32768, 0, 1);
    push_score(32767, 0, 0);
    push_score(32767, 1, 1);
    // negative scores, first class stays the maximum
    push_score(-1, 0, 0);
    push_score(-32768, 1, 0);
    // alternating bit patterns
    push_score(16'h5555, 0, 0);
    push_score(int'(16'hAAAA) - 65536, 0, 0);
    push_score(16'h2AAA, 1, 1);
    push_drain();
    scores_made = 0;
    rows_made   = 0;
    while (scores_made < RANDOM_SCORES || rows_made < MIN_ROWS) begin
      push_random_row();
      if (scores_made >= RANDOM_SCORES / 2 && scores_made - RANDOM_SCORES / 2 < 73 &&
          rows_made > 0 && score_feed[score_feed.size() - 1].row_end) begin
        if (!score_feed[score_feed.size() - 1].drain) push_drain();
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    while (score_feed.size() != 0 || s_tvalid || step_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && step_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // slave side driver
  always @(posedge clk_i) begin
    if (!rst_n) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready_o) decode_score(drv_item);
      if (!s_tvalid || s_tready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (score_feed.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (score_feed[0].drain) begin
          // pause until every row result is out, then let the block settle
          s_tvalid <= 1'b0;
          if (step_results.size() != 0) drain_settle = 0;
          else if (drain_settle < SETTLE_CYCLES) drain_settle++;
          else begin
            score_feed.delete(0);
            drain_settle = 0;
          end
        end else begin
          drv_item = score_feed.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= drv_item.score;
          s_tlast  <= drv_item.row_end;
          s_tuser  <= drv_item.word_end;
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 15);
        end
      end
    end
  end

  // master side monitor and ready pattern
  always @(posedge clk_i) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid_o && m_tready) begin
        if (step_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, best_class %0d",
                                    m_tdata_o[13:8]));
        end else begin
          want = step_results.pop_front();
          if (m_tuser_o !== want.symbol_valid)
            report_mismatch($sformatf("symbol_valid %b, expected %b",
                                      m_tuser_o, want.symbol_valid));
          if (m_tdata_o[7:0] !== want.symbol_code)
            report_mismatch($sformatf("symbol_code %h, expected %h",
                                      m_tdata_o[7:0], want.symbol_code));
          if (m_tdata_o[13:8] !== want.best_class)
            report_mismatch($sformatf("best_class %0d, expected %0d",
                                      m_tdata_o[13:8], want.best_class));
          if (m_tlast_o !== want.sequence_done)
            report_mismatch($sformatf("sequence_done %b, expected %b",
                                      m_tlast_o, want.sequence_done));
        end
        results_seen++;
        // long back-pressure so the result queue fills and the input stalls
        if (results_seen == 12 || results_seen == 45) hold_left = LONG_HOLD;
        if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
        recv_gap = recv_burst ? 0 : $urandom_range(0, 15);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_n || (s_tvalid && s_tready_o) || (m_tvalid_o && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout at %0t ns", $time);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
